// ----- hdl/track_mixer_turret_pd_servo_defines.svh -----
// Assertion macros shared by the servo mixer RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef TRACK_MIXER_TURRET_PD_SERVO_DEFINES_SVH
`define TRACK_MIXER_TURRET_PD_SERVO_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define TMTPS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define TMTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tmtps_pkg.sv -----
// Types and constants for the track mixer and turret PD servo.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmtps_pkg;

    localparam int CMD_W   = 16;
    localparam int ANG_W   = 24;
    localparam int TRK_W   = 19;
    localparam int DRV_W   = 32;
    localparam int TPS_W   = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_TRACK_MODE  = 3'd0;
    localparam logic [2:0] REG_TURRET_MODE = 3'd1;
    localparam logic [2:0] REG_TICKS       = 3'd2;
    localparam logic [2:0] REG_INIT_YAW    = 3'd3;
    localparam logic [2:0] REG_INIT_PITCH  = 3'd4;

    localparam logic [TPS_W-1:0] TICKS_RESET = 16'd1000;

    // Deadband limits in Q.12 counts.
    localparam logic [CMD_W:0] TRACK_DB  = 17'd819;
    localparam logic [CMD_W:0] TURRET_DB = 17'd614;

    // Reference step: round(4*|c| / 125) as ((4*|c| + 62) * 268436) >> 25.
    localparam logic [17:0]        ROUND_BIAS  = 18'd62;
    localparam logic [MUL_B_W-1:0] RECIP_125   = 24'd268436;
    localparam int                 RECIP_SHIFT = 25;
    localparam logic [MUL_B_W-1:0] P_GAIN      = 24'd200;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRACK,
        S_DIV,
        S_REF,
        S_PMUL,
        S_DMUL,
        S_SUM,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                      track_mode;
        logic                      turret_mode;
        logic [TPS_W-1:0]          ticks;
        logic [1:0]                load;
        logic [1:0][ANG_W-1:0]     init_angle;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/track_mixer_turret_pd_servo.sv -----
// Track mixer and turret PD servo: top level with the sequencer and datapath.
// Depends on tmtps_pkg, tmtps_cfg, tmtps_mul and the assertion macro header.
//
// One input beat per control tick carries four Q.12 commands and two Q.16
// measured turret angles; one output beat returns two track speeds and two
// turret drives. Both channels use valid and ready. The APB port sets the
// modes, the tick rate and the start angles; the user is to write it while
// idle, as the block itself does not enforce this. The input is taken only
// in the idle state. The track speeds are worked out in TRACK; each turret
// joint then runs through the shared multiplier three times (reference
// step, P term, D term) over DIV, REF, PMUL, DMUL and SUM in torque mode,
// and through DIV alone, not using the product, in velocity mode. The
// sequencer returns to idle as the result moves to the output register.
// The result sits in an output register, so a new input can be accepted
// while it waits; if the receiver still stalls when the next result is
// ready, the sequencer holds until the register frees.
// Reset clears the registers to their defaults (tick rate 1000, angles 0)
// and the joint reference and previous angles to zero.
`default_nettype none

`include "track_mixer_turret_pd_servo_defines.svh"

module track_mixer_turret_pd_servo
    import tmtps_pkg::*;
#(
    parameter int TURRET_JOINTS = 2
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic      [PDATA_W-1:0]      prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [CMD_W-1:0] track_turn_cmd,
    input  wire logic signed [CMD_W-1:0] track_forward_cmd,
    input  wire logic signed [CMD_W-1:0] turret_yaw_cmd,
    input  wire logic signed [CMD_W-1:0] turret_pitch_cmd,
    input  wire logic signed [ANG_W-1:0] measured_yaw_angle,
    input  wire logic signed [ANG_W-1:0] measured_pitch_angle,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed      [TRK_W-1:0] left_track_speed,
    output logic signed      [TRK_W-1:0] right_track_speed,
    output logic signed      [DRV_W-1:0] yaw_drive,
    output logic signed      [DRV_W-1:0] pitch_drive
);

    // Only the yaw and pitch joints are driven; further joints stay idle.
    localparam int ACTIVE_JOINTS = (TURRET_JOINTS < 2) ? TURRET_JOINTS : 2;

    cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic signed [CMD_W-1:0] turn_reg;
    logic signed [CMD_W-1:0] fwd_reg;
    logic signed [CMD_W-1:0] cmd_reg [2];
    logic signed [ANG_W-1:0] ang_reg [2];

    logic signed [ANG_W-1:0] ref_reg  [ACTIVE_JOINTS];
    logic signed [ANG_W-1:0] prev_reg [ACTIVE_JOINTS];

    logic                    jdx_reg;
    logic signed [12:0]      d_reg;
    logic signed [ANG_W-1:0] r_reg;
    logic signed [25:0]      e_reg;
    logic signed [33:0]      p1_reg;

    logic signed [TRK_W-1:0] left_stage_reg;
    logic signed [TRK_W-1:0] right_stage_reg;
    logic signed [DRV_W-1:0] drive_stage_reg [2];

    logic                    out_valid_reg;
    logic signed [TRK_W-1:0] left_out_reg;
    logic signed [TRK_W-1:0] right_out_reg;
    logic signed [DRV_W-1:0] yaw_out_reg;
    logic signed [DRV_W-1:0] pitch_out_reg;

    logic                    last_joint;
    logic                    fin_load;
    logic signed [CMD_W-1:0] c_db;
    logic                    c_pos;
    logic        [CMD_W:0]   c_abs;
    logic        [17:0]      x_div;
    logic        [11:0]      quot;
    logic signed [12:0]      d_val;
    logic signed [ANG_W:0]   ref_sum;
    logic signed [ANG_W-1:0] r_val;
    logic signed [ANG_W-1:0] q_ang;
    logic signed [ANG_W:0]   diff_rq;
    logic signed [25:0]      e_val;
    logic        [21:0]      tps50;
    logic signed [51:0]      u_sum;
    logic signed [20:0]      vel_val;
    logic signed [CMD_W-1:0] turn_db;
    logic signed [CMD_W-1:0] fwd_db;
    logic signed [17:0]      mix_l;
    logic signed [17:0]      mix_r;
    logic signed [19:0]      scale_l;
    logic signed [19:0]      scale_r;

    function automatic logic signed [CMD_W-1:0] deadband(
        input logic signed [CMD_W-1:0] c,
        input logic        [CMD_W:0]   lim
    );
        logic [CMD_W:0] mag;
        mag = c[CMD_W-1] ? -{c[CMD_W-1], c} : {c[CMD_W-1], c};
        return (mag <= lim) ? '0 : c;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ANG_W:0] v);
        if (v[ANG_W] != v[ANG_W-1])
            return v[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
        return v[ANG_W-1:0];
    endfunction

    function automatic logic signed [TRK_W-1:0] sat_trk(input logic signed [19:0] v);
        if (v[19] != v[18])
            return v[19] ? {1'b1, {(TRK_W-1){1'b0}}} : {1'b0, {(TRK_W-1){1'b1}}};
        return v[TRK_W-1:0];
    endfunction

    function automatic logic signed [DRV_W-1:0] sat_drv(input logic signed [51:0] v);
        logic hi_ok;
        hi_ok = (v[51:DRV_W-1] == '0) || (v[51:DRV_W-1] == '1);
        if (!hi_ok)
            return v[51] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
        return v[DRV_W-1:0];
    endfunction

    tmtps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmtps_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (mul_prod)
    );

    assign last_joint = (jdx_reg == 1'(ACTIVE_JOINTS - 1));
    assign fin_load   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // Per-joint arithmetic around the shared multiplier.
    always_comb
    begin
        c_db    = deadband(cmd_reg[jdx_reg], TURRET_DB);
        c_pos   = !c_db[CMD_W-1] && (c_db != '0);
        c_abs   = c_db[CMD_W-1] ? -{c_db[CMD_W-1], c_db} : {c_db[CMD_W-1], c_db};
        x_div   = 18'({c_abs, 2'b00}) + ROUND_BIAS;
        quot    = mul_prod[RECIP_SHIFT+11:RECIP_SHIFT];
        d_val   = c_pos ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        ref_sum = {ref_reg[jdx_reg][ANG_W-1], ref_reg[jdx_reg]}
                  + {{(ANG_W-12){d_val[12]}}, d_val};
        r_val   = sat_ang(ref_sum);
        q_ang   = ang_reg[jdx_reg];
        diff_rq = {r_reg[ANG_W-1], r_reg} - {q_ang[ANG_W-1], q_ang};
        e_val   = {{13{d_reg[12]}}, d_reg} - {{2{q_ang[ANG_W-1]}}, q_ang}
                  + {{2{prev_reg[jdx_reg][ANG_W-1]}}, prev_reg[jdx_reg]};
        tps50   = 22'({cfg.ticks, 5'b0}) + 22'({cfg.ticks, 4'b0})
                  + 22'({cfg.ticks, 1'b0});
        u_sum   = {{18{p1_reg[33]}}, p1_reg} + {mul_prod[MUL_P_W-1], mul_prod};
        vel_val = -({{5{c_db[CMD_W-1]}}, c_db} <<< 4);
    end

    // Track mixing: left = k*(-fwd - turn), right = k*(-fwd + turn).
    always_comb
    begin
        turn_db = deadband(turn_reg, TRACK_DB);
        fwd_db  = deadband(fwd_reg, TRACK_DB);
        mix_l   = -{{2{fwd_db[CMD_W-1]}}, fwd_db} - {{2{turn_db[CMD_W-1]}}, turn_db};
        mix_r   = -{{2{fwd_db[CMD_W-1]}}, fwd_db} + {{2{turn_db[CMD_W-1]}}, turn_db};
        scale_l = cfg.track_mode ? {mix_l, 2'b00} : {{2{mix_l[17]}}, mix_l};
        scale_r = cfg.track_mode ? {mix_r, 2'b00} : {{2{mix_r[17]}}, mix_r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_TRACK;
            S_TRACK: state_next = S_DIV;
            S_DIV:
            begin
                if (!cfg.turret_mode)
                    state_next = S_REF;
                else if (last_joint)
                    state_next = S_FIN;
            end
            S_REF:   state_next = S_PMUL;
            S_PMUL:  state_next = S_DMUL;
            S_DMUL:  state_next = S_SUM;
            S_SUM:   state_next = last_joint ? S_FIN : S_DIV;
            S_FIN:   if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_DIV:
            begin
                mul_a = $signed({9'd0, x_div});
                mul_b = $signed(RECIP_125);
            end
            S_PMUL:
            begin
                mul_a = {{2{diff_rq[ANG_W]}}, diff_rq};
                mul_b = $signed(P_GAIN);
            end
            S_DMUL:
            begin
                mul_a = {e_reg[25], e_reg};
                mul_b = $signed({2'b00, tps50});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jdx_reg <= 1'b0;
        end
        else if (state_reg == S_TRACK)
        begin
            jdx_reg <= 1'b0;
        end
        else if ((state_reg == S_SUM) || ((state_reg == S_DIV) && cfg.turret_mode))
        begin
            jdx_reg <= !last_joint;
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    turn_reg   <= track_turn_cmd;
                    fwd_reg    <= track_forward_cmd;
                    cmd_reg[0] <= turret_yaw_cmd;
                    cmd_reg[1] <= turret_pitch_cmd;
                    ang_reg[0] <= measured_yaw_angle;
                    ang_reg[1] <= measured_pitch_angle;
                end
            end
            S_TRACK:
            begin
                left_stage_reg     <= sat_trk(scale_l);
                right_stage_reg    <= sat_trk(scale_r);
                drive_stage_reg[0] <= '0;
                drive_stage_reg[1] <= '0;
            end
            S_DIV:
            begin
                if (cfg.turret_mode)
                    drive_stage_reg[jdx_reg] <= {{(DRV_W-21){vel_val[20]}}, vel_val};
            end
            S_REF:
            begin
                d_reg <= d_val;
                r_reg <= r_val;
            end
            S_PMUL:  e_reg <= e_val;
            S_DMUL:  p1_reg <= mul_prod[33:0];
            S_SUM:   drive_stage_reg[jdx_reg] <= sat_drv(u_sum);
            default: ;
        endcase
    end

    // Joint state: loaded by a start-angle write, advanced at the end of a torque step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ACTIVE_JOINTS; k++)
            begin
                ref_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < ACTIVE_JOINTS; k++)
            begin
                if (cfg.load[k])
                begin
                    ref_reg[k]  <= cfg.init_angle[k];
                    prev_reg[k] <= cfg.init_angle[k];
                end
            end
            if (state_reg == S_SUM)
            begin
                ref_reg[jdx_reg]  <= r_reg;
                prev_reg[jdx_reg] <= ang_reg[jdx_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            left_out_reg  <= left_stage_reg;
            right_out_reg <= right_stage_reg;
            yaw_out_reg   <= drive_stage_reg[0];
            pitch_out_reg <= drive_stage_reg[1];
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_track_speed  = left_out_reg;
    assign right_track_speed = right_out_reg;
    assign yaw_drive         = yaw_out_reg;
    assign pitch_drive       = pitch_out_reg;

    `TMTPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && state_reg == S_TRACK, "input taken while a beat is in work")
    `TMTPS_ASSERT_NEXT(a_fin_loads_output, fin_load, out_valid_reg && state_reg == S_IDLE, "finished result not moved to the output register")
    `TMTPS_ASSERT_NEXT(a_fin_holds_on_stall, state_reg == S_FIN && out_valid_reg && !out_ready, state_reg == S_FIN && out_valid_reg, "result dropped while the receiver stalls")
    `TMTPS_ASSERT_ALWAYS(a_joint_in_range, state_reg == S_IDLE || state_reg == S_TRACK || jdx_reg <= 1'(ACTIVE_JOINTS - 1), "joint index beyond the driven joints")

endmodule

`default_nettype wire

// ----- hdl/tmtps_cfg.sv -----
// APB register bank for the servo mixer: modes, tick rate and start angles.
// Depends on tmtps_pkg; a start-angle write raises a load strobe for its joint.
`default_nettype none

module tmtps_cfg
    import tmtps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic             track_mode_reg;
    logic             turret_mode_reg;
    logic [TPS_W-1:0] ticks_reg;
    logic [ANG_W-1:0] init_yaw_reg;
    logic [ANG_W-1:0] init_pitch_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_mode_reg  <= 1'b0;
            turret_mode_reg <= 1'b0;
            ticks_reg       <= TICKS_RESET;
            init_yaw_reg    <= '0;
            init_pitch_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TRACK_MODE:  track_mode_reg  <= pwdata[0];
                REG_TURRET_MODE: turret_mode_reg <= pwdata[0];
                REG_TICKS:       ticks_reg       <= pwdata[TPS_W-1:0];
                REG_INIT_YAW:    init_yaw_reg    <= pwdata[ANG_W-1:0];
                REG_INIT_PITCH:  init_pitch_reg  <= pwdata[ANG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRACK_MODE:  prdata = {31'd0, track_mode_reg};
            REG_TURRET_MODE: prdata = {31'd0, turret_mode_reg};
            REG_TICKS:       prdata = {16'd0, ticks_reg};
            REG_INIT_YAW:    prdata = {{8{init_yaw_reg[ANG_W-1]}}, init_yaw_reg};
            REG_INIT_PITCH:  prdata = {{8{init_pitch_reg[ANG_W-1]}}, init_pitch_reg};
            default:         prdata = '0;
        endcase
    end

    // The joint state takes the written angle in the same edge as the register.
    always_comb
    begin
        cfg.track_mode    = track_mode_reg;
        cfg.turret_mode   = turret_mode_reg;
        cfg.ticks         = ticks_reg;
        cfg.load[0]       = wr_en && (reg_idx == REG_INIT_YAW);
        cfg.load[1]       = wr_en && (reg_idx == REG_INIT_PITCH);
        cfg.init_angle[0] = pwdata[ANG_W-1:0];
        cfg.init_angle[1] = pwdata[ANG_W-1:0];
    end

endmodule

`default_nettype wire

// ----- hdl/tmtps_mul.sv -----
// Shared signed multiplier of the servo datapath with a registered product.
// Depends on tmtps_pkg for operand widths; the product appears in the cycle after its operands.
`default_nettype none

module tmtps_mul
    import tmtps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] mul_a,
    input  wire logic signed [MUL_B_W-1:0] mul_b,
    output logic signed      [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
